/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared widths, command codes, cell operation codes and the cell control
// struct used by the queue top level and its storage cells.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int WORD_W        = 32;
	localparam int FUNC_W        = 3;
	localparam int DEPTH_DEFAULT = 32;

	// Command codes carried on the input tuser.
	localparam logic [FUNC_W-1:0] FUNC_PUSH_TAIL = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_HEAD = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP_HEAD  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_TAIL  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DUMP      = 3'd4;

	// Operations broadcast to every cell in the chain.
	localparam int CELL_OP_W = 3;
	localparam logic [CELL_OP_W-1:0] CELL_HOLD    = 3'd0;
	localparam logic [CELL_OP_W-1:0] CELL_LOAD_AT = 3'd1;
	localparam logic [CELL_OP_W-1:0] CELL_SHIFT_R = 3'd2;
	localparam logic [CELL_OP_W-1:0] CELL_SHIFT_L = 3'd3;
	localparam logic [CELL_OP_W-1:0] CELL_ROTATE  = 3'd4;

	typedef struct packed {
		logic [CELL_OP_W-1:0] op;
		logic [WORD_W-1:0]    word;
		logic [WORD_W-1:0]    wrap_word;
	} cell_ctl_t;

endpackage

/* rtl/deq_cell.sv */
// ----------------------------------------------------------------------------
// Queue storage cell
// Holds one word of the queue. Cell zero is the head; each cycle a cell can
// keep its word, load the pushed word, or take a neighbor's word.
// ----------------------------------------------------------------------------
module deq_cell
	import deq_pkg::*;
#(
	parameter int CW  = 6,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [CW-1:0]     count,
	input  logic [WORD_W-1:0] left_data,
	input  logic [WORD_W-1:0] right_data,
	output logic [WORD_W-1:0] data_q
);

	localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
	localparam logic [CW:0]   NEXT_IDX = (CW+1)'(IDX + 1);

	logic [CW:0] count_ext;

	assign count_ext = {1'b0, count};

	// The word store has no reset: only entries that a push wrote are read.
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_LOAD_AT: begin
				if (count == MY_IDX) begin
					data_q <= ctl.word;
				end
			end
			CELL_SHIFT_R: data_q <= left_data;
			CELL_SHIFT_L: data_q <= right_data;
			CELL_ROTATE: begin
				// The tail cell of the occupied run receives the old head word.
				if (NEXT_IDX < count_ext) begin
					data_q <= right_data;
				end else if (NEXT_IDX == count_ext) begin
					data_q <= ctl.wrap_word;
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/double_ended_queue.sv */
// Push and pop commands give no result.
// A dump of n entries is accepted and starts the dump state; its results leave the output
// register one per cycle while the output is not back-pressured, and the input stays stalled
// while the cell chain rotates once around the occupied run.
// An empty dump gives its single result in the cycle after acceptance.
// Reset clears the fill count, overflow flag, dump control and output valid.
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of words built from a chain of shifting cells, with
// head and tail push and pop and a streaming dump from head to tail.
// ----------------------------------------------------------------------------
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,  // [31:0] value
	input  logic [FUNC_W-1:0] s_tuser,  // [2:0] func
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata,  // [31:0] entry
	output logic              m_tlast,  // last
	output logic [1:0]        m_tuser   // [0] is_empty, [1] dropped
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE        = CW'(1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic              state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;
	logic              overflow_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_entry_q;
	logic              out_last_q;
	logic              out_empty_q;
	logic              out_dropped_q;

	logic              in_acc;
	logic              out_free;
	logic              full;
	logic              dump_last;
	cell_ctl_t         ctl;
	logic [WORD_W-1:0] cell_data [DEPTH];

	logic              state_d;
	logic [CW-1:0]     count_d;
	logic [CW-1:0]     k_d;
	logic              overflow_d;
	logic              out_load;
	logic [WORD_W-1:0] out_entry_d;
	logic              out_last_d;
	logic              out_empty_d;

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign in_acc    = s_tvalid && s_tready;
	assign full      = (count_q == FULL_COUNT);
	assign dump_last = (k_q == count_q - ONE);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		k_d         = k_q;
		overflow_d  = overflow_q;
		out_load    = 1'b0;
		out_entry_d = cell_data[0];
		out_last_d  = 1'b0;
		out_empty_d = 1'b0;
		ctl.op        = CELL_HOLD;
		ctl.word      = s_tdata;
		ctl.wrap_word = cell_data[0];

		if (state_q == ST_DUMP) begin
			if (out_free) begin
				ctl.op     = CELL_ROTATE;
				out_load   = 1'b1;
				out_last_d = dump_last;
				k_d        = k_q + ONE;
				if (dump_last) begin
					state_d = ST_IDLE;
				end
			end
		end else if (in_acc) begin
			unique case (s_tuser)
				FUNC_PUSH_TAIL: begin
					if (full) begin
						overflow_d = 1'b1;
					end else begin
						ctl.op  = CELL_LOAD_AT;
						count_d = count_q + ONE;
					end
				end
				FUNC_PUSH_HEAD: begin
					if (full) begin
						overflow_d = 1'b1;
					end else begin
						ctl.op  = CELL_SHIFT_R;
						count_d = count_q + ONE;
					end
				end
				FUNC_POP_HEAD: begin
					if (count_q != '0) begin
						ctl.op  = CELL_SHIFT_L;
						count_d = count_q - ONE;
					end
				end
				FUNC_POP_TAIL: begin
					if (count_q != '0) begin
						count_d = count_q - ONE;
					end
				end
				FUNC_DUMP: begin
					if (count_q == '0) begin
						out_load    = 1'b1;
						out_entry_d = '0;
						out_last_d  = 1'b1;
						out_empty_d = 1'b1;
					end else begin
						state_d = ST_DUMP;
						k_d     = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			k_q        <= k_d;
			overflow_q <= overflow_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_entry_q   <= out_entry_d;
			out_last_q    <= out_last_d;
			out_empty_q   <= out_empty_d;
			out_dropped_q <= overflow_q;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;

		if (i == 0) begin : g_head
			assign left_w = ctl.word;
		end else begin : g_mid
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign right_w = cell_data[i];
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end

		deq_cell #(
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.left_data  (left_w),
			.right_data (right_w),
			.data_q     (cell_data[i])
		);
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_entry_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_dropped_q, out_empty_q};

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("fill count exceeds depth");

	a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> !s_tready)
		else $error("input accepted during dump");

	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP && out_free && dump_last) |=> state_q == ST_IDLE)
		else $error("dump did not end after last entry");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("empty dump result without last mark");
`endif

endmodule

/* verif/deq_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Watches the command and dump streams of the queue, keeps its own ring
// buffer image of the queue contents, and compares every dump transaction
// field by field against the entries it predicts.
// ----------------------------------------------------------------------------
module deq_checker
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // [31:0] value
	input  logic [FUNC_W-1:0] s_tuser,   // [2:0] func
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [WORD_W-1:0] m_tdata,   // [31:0] entry
	input  logic              m_tlast,   // last
	input  logic [1:0]        m_tuser,   // [0] is_empty, [1] dropped
	output int                beats_owed,
	output int                mismatch_count
);

	typedef struct {
		logic [WORD_W-1:0] entry;
		logic              last;
		logic              is_empty;
		logic              dropped;
	} dump_beat_t;

	logic [WORD_W-1:0] ring [DEPTH];
	int unsigned       head_slot;
	int unsigned       fill_level;
	logic              overflow_seen;
	dump_beat_t        owed_beats [$];

	// Updates the queue image for one accepted command and queues the dump
	// transactions it should produce.
	function automatic void apply_command(input logic [FUNC_W-1:0] func,
			input logic [WORD_W-1:0] value);
		dump_beat_t beat;
		case (func)
			FUNC_PUSH_TAIL: begin
				if (fill_level >= DEPTH) begin
					overflow_seen = 1'b1;
				end else begin
					ring[(head_slot + fill_level) % DEPTH] = value;
					fill_level++;
				end
			end
			FUNC_PUSH_HEAD: begin
				if (fill_level >= DEPTH) begin
					overflow_seen = 1'b1;
				end else begin
					head_slot = (head_slot + DEPTH - 1) % DEPTH;
					ring[head_slot] = value;
					fill_level++;
				end
			end
			FUNC_POP_HEAD: begin
				if (fill_level != 0) begin
					head_slot = (head_slot + 1) % DEPTH;
					fill_level--;
				end
			end
			FUNC_POP_TAIL: begin
				if (fill_level != 0)
					fill_level--;
			end
			FUNC_DUMP: begin
				if (fill_level == 0) begin
					beat.entry    = '0;
					beat.last     = 1'b1;
					beat.is_empty = 1'b1;
					beat.dropped  = overflow_seen;
					owed_beats.push_back(beat);
				end else begin
					for (int unsigned k = 0; k < fill_level; k++) begin
						beat.entry    = ring[(head_slot + k) % DEPTH];
						beat.last     = (k + 1 == fill_level);
						beat.is_empty = 1'b0;
						beat.dropped  = overflow_seen;
						owed_beats.push_back(beat);
					end
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		dump_beat_t want;
		int         errs;
		if (!arst_n) begin
			head_slot      = 0;
			fill_level     = 0;
			overflow_seen  = 1'b0;
			owed_beats.delete();
			beats_owed     <= 0;
			mismatch_count <= 0;
		end else begin
			errs = 0;
			if (s_tvalid && s_tready)
				apply_command(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (owed_beats.size() == 0) begin
					$display("%0t: unexpected dump transaction: expected none,",
						$time,
						" actual entry %h last %b user %b",
						m_tdata, m_tlast, m_tuser);
					errs++;
				end else begin
					want = owed_beats.pop_front();
					if (m_tdata !== want.entry) begin
						$display("%0t: entry mismatch: expected %h, actual %h",
							$time, want.entry, m_tdata);
						errs++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last mismatch: expected %b, actual %b",
							$time, want.last, m_tlast);
						errs++;
					end
					if (m_tuser[0] !== want.is_empty) begin
						$display("%0t: is_empty mismatch: expected %b, actual %b",
							$time, want.is_empty, m_tuser[0]);
						errs++;
					end
					if (m_tuser[1] !== want.dropped) begin
						$display("%0t: dropped mismatch: expected %b, actual %b",
							$time, want.dropped, m_tuser[1]);
						errs++;
					end
				end
			end
			beats_owed     <= owed_beats.size();
			mismatch_count <= mismatch_count + errs;
		end
	end

endmodule

/* verif/double_ended_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives directed and random command streams into the queue, with fill,
// drain and mixed rounds under changing backpressure, and reports the
// verdict from the checker's mismatch and owed-transaction counts.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
	import deq_pkg::*;

	localparam int DEPTH        = DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS = 290;
	localparam int CYCLE_LIMIT  = 400000;

	// Command codes the queue ignores.
	localparam logic [FUNC_W-1:0] FUNC_RSVD_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_LAST  = 3'd7;

	typedef enum {ROUND_FILL, ROUND_DRAIN, ROUND_MIX} round_kind_t;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [WORD_W-1:0] s_tdata  = '0;  // [31:0] value
	logic [FUNC_W-1:0] s_tuser  = '0;  // [2:0] func
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [WORD_W-1:0] m_tdata;        // [31:0] entry
	logic              m_tlast;
	logic [1:0]        m_tuser;        // [0] is_empty, [1] dropped

	int beats_owed;
	int mismatch_count;
	int tx_idle_pct = 35;
	int rx_idle_pct = 47;
	int items_sent  = 0;
	int cycle_count = 0;

	double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	deq_checker #(.DEPTH(DEPTH)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.beats_owed     (beats_owed),
		.mismatch_count (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one command and returns at the edge where it is accepted. Valid
	// stays high into the next command unless an idle gap is drawn.
	task automatic send_cmd(input logic [FUNC_W-1:0] func,
			input logic [WORD_W-1:0] value);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Holds the command stream off until every predicted dump transaction is back.
	task automatic wait_for_dumps();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (beats_owed != 0)
			@(posedge clk);
	endtask

	function automatic logic [FUNC_W-1:0] push_func();
		return $urandom_range(0, 1) ? FUNC_PUSH_HEAD : FUNC_PUSH_TAIL;
	endfunction

	function automatic logic [FUNC_W-1:0] pop_func();
		return $urandom_range(0, 1) ? FUNC_POP_HEAD : FUNC_POP_TAIL;
	endfunction

	function automatic logic [FUNC_W-1:0] mixed_func();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return FUNC_PUSH_TAIL;
		if (r < 55)
			return FUNC_PUSH_HEAD;
		if (r < 70)
			return FUNC_POP_HEAD;
		if (r < 85)
			return FUNC_POP_TAIL;
		if (r < 95)
			return FUNC_DUMP;
		return FUNC_RSVD_FIRST
			+ FUNC_W'($urandom_range(0, FUNC_RSVD_LAST - FUNC_RSVD_FIRST));
	endfunction

	initial begin : stimulus
		round_kind_t kind;
		int          random_start;
		int          round;
		int unsigned pick;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue: dump, pops that must be ignored, and the unused codes.
		send_cmd(FUNC_DUMP, 32'h0000_0000);
		send_cmd(FUNC_POP_HEAD, 32'hFFFF_FFFF);
		send_cmd(FUNC_POP_TAIL, 32'hFFFF_FFFF);
		send_cmd(FUNC_RSVD_FIRST, 32'hFFFF_FFFF);
		send_cmd(FUNC_RSVD_FIRST + 1'b1, 32'h5555_5555);
		send_cmd(FUNC_RSVD_LAST, 32'hAAAA_AAAA);
		send_cmd(FUNC_DUMP, 32'hFFFF_FFFF);
		// Extreme values at both ends; the head push wraps the head slot.
		send_cmd(FUNC_PUSH_TAIL, 32'h7FFF_FFFF);
		send_cmd(FUNC_PUSH_HEAD, 32'h8000_0000);
		send_cmd(FUNC_PUSH_TAIL, 32'h0000_0000);
		send_cmd(FUNC_PUSH_HEAD, 32'hFFFF_FFFF);
		send_cmd(FUNC_DUMP, 32'h0000_0000);
		send_cmd(FUNC_POP_HEAD, 32'h0000_0000);
		send_cmd(FUNC_DUMP, 32'h0000_0000);
		send_cmd(FUNC_POP_TAIL, 32'h0000_0000);
		send_cmd(FUNC_DUMP, 32'h0000_0000);
		send_cmd(FUNC_POP_HEAD, 32'h0000_0000);
		send_cmd(FUNC_POP_TAIL, 32'h0000_0000);
		send_cmd(FUNC_DUMP, 32'h0000_0000);
		send_cmd(FUNC_POP_TAIL, 32'h1234_5678);

		random_start = items_sent;
		round = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (tx_idle_pct == 35
					&& items_sent - random_start >= RANDOM_ITEMS / 3) begin
				wait_for_dumps();
				tx_idle_pct = 47;
				rx_idle_pct = 35;
			end else if (tx_idle_pct == 47
					&& items_sent - random_start >= 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			if (round == 0) begin
				kind = ROUND_FILL;
			end else if (round == 1) begin
				kind = ROUND_DRAIN;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					kind = ROUND_FILL;
				end else if (pick < 45) begin
					kind = ROUND_DRAIN;
				end else begin
					kind = ROUND_MIX;
				end
			end
			round++;

			case (kind)
				ROUND_FILL: begin
					// Enough pushes to fill from any level and hit the full case.
					repeat (DEPTH + 2) send_cmd(push_func(), $urandom());
					send_cmd(FUNC_DUMP, $urandom());
				end
				ROUND_DRAIN: begin
					repeat (DEPTH + 2) send_cmd(pop_func(), $urandom());
					send_cmd(FUNC_DUMP, $urandom());
				end
				default: begin
					repeat (20) send_cmd(mixed_func(), $urandom());
				end
			endcase
		end

		wait_for_dumps();
		repeat (DEPTH + 8) @(posedge clk);
		if (beats_owed != 0)
			$display("%0t: %0d predicted dump transactions never arrived", $time, beats_owed);
		if (mismatch_count == 0 && beats_owed == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
